>>> rtl/pss_pkg.sv
// Shared constants, types and the trig table builder for the pie sector span block.
`default_nettype none
package pss_pkg;

  localparam int SECTORS      = 8;
  localparam int ARC_SAMPLES  = 180;
  localparam int TRIG_D       = SECTORS * ARC_SAMPLES;
  localparam int NM_W         = $clog2(TRIG_D);
  localparam int SAMPLE_W     = $clog2(ARC_SAMPLES + 1);

  localparam int SEC_W        = 3;
  localparam int SECTOR_CODES = 2 ** SEC_W;
  localparam int ROW_W        = 10;
  localparam int COLOR_W      = 16;
  localparam int CX_W         = 10;
  localparam int RAD_W        = 9;
  localparam int SCR_W        = 11;
  localparam int LEN_W        = 11;
  localparam int MAG_W        = 15;
  localparam int DELTA_W      = 9;
  localparam int COORD_W      = 12;
  localparam int PROD_W       = RAD_W + MAG_W;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 11;

  localparam int MAX_COLS     = 1024;
  localparam int Q15_MAX      = 32767;

  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER_X      = 3'd0,
    REG_CENTER_Y      = 3'd1,
    REG_WHEEL_RADIUS  = 3'd2,
    REG_SCREEN_WIDTH  = 3'd3,
    REG_SCREEN_HEIGHT = 3'd4
  } cfg_reg_t;

  // cosine and sine in sign/magnitude Q1.15
  typedef struct packed {
    logic             neg_c;
    logic [MAG_W-1:0] mag_c;
    logic             neg_s;
    logic [MAG_W-1:0] mag_s;
  } trig_t;

  // radius-scaled offsets from the wheel center
  typedef struct packed {
    logic               neg_x;
    logic [DELTA_W-1:0] mag_x;
    logic               neg_y;
    logic [DELTA_W-1:0] mag_y;
  } pss_point_t;

  function automatic logic [MAG_W-1:0] to_q15(logic [63:0] v);
    logic [63:0] q;
    q = (v + 64'd16384) >> 15;
    if (q > 64'(Q15_MAX)) q = 64'(Q15_MAX);
    return q[MAG_W-1:0];
  endfunction

  // Table entry for turn index nm (0 .. TRIG_D-1); evaluated at elaboration only.
  function automatic trig_t trig_entry(int unsigned nm);
    logic [63:0]      p64;
    logic [63:0]      x;
    logic [63:0]      t;
    logic [63:0]      t2;
    logic [63:0]      a;
    logic [63:0]      s;
    logic [63:0]      c;
    logic [31:0]      p;
    logic             fold;
    logic [MAG_W-1:0] sq;
    logic [MAG_W-1:0] cq;
    logic [MAG_W-1:0] cb;
    logic [MAG_W-1:0] sb;
    trig_t            e;
    p64  = (64'(nm) << 32) / 64'(TRIG_D);
    p    = p64[31:0];
    fold = (p[29:0] > 30'h2000_0000);
    x    = fold ? (ONE_Q30 - 64'(p[29:0])) : 64'(p[29:0]);
    t    = (x * PI_Q30) >> 31;
    t2   = (t * t) >> 30;

    a = ONE_Q30 - t2 / 64'd42;
    a = ONE_Q30 - ((t2 * a) >> 30) / 64'd20;
    a = ONE_Q30 - ((t2 * a) >> 30) / 64'd6;
    s = (t * a) >> 30;

    a = ONE_Q30 - t2 / 64'd56;
    a = ONE_Q30 - ((t2 * a) >> 30) / 64'd30;
    a = ONE_Q30 - ((t2 * a) >> 30) / 64'd12;
    c = ONE_Q30 - ((t2 * a) >> 30) / 64'd2;

    sq = to_q15(s);
    cq = to_q15(c);
    cb = fold ? sq : cq;
    sb = fold ? cq : sq;
    case (p[31:30])
      2'd0: begin
        e.neg_c = 1'b0; e.mag_c = cb; e.neg_s = 1'b0; e.mag_s = sb;
      end
      2'd1: begin
        e.neg_c = 1'b1; e.mag_c = sb; e.neg_s = 1'b0; e.mag_s = cb;
      end
      2'd2: begin
        e.neg_c = 1'b1; e.mag_c = cb; e.neg_s = 1'b1; e.mag_s = sb;
      end
      default: begin
        e.neg_c = 1'b0; e.mag_c = sb; e.neg_s = 1'b1; e.mag_s = cb;
      end
    endcase
    return e;
  endfunction

endpackage
`default_nettype wire

>>> rtl/pss_trig_rom.sv
// Cosine/sine lookup table over one full turn, registered read.
`default_nettype none
module pss_trig_rom
  import pss_pkg::*;
(
  input  wire logic            clk,
  input  wire logic [NM_W-1:0] addr,
  output trig_t                trig
);

  trig_t rom_w [TRIG_D];
  trig_t trig_r;

  for (genvar g = 0; g < TRIG_D; g++) begin : g_rom
    localparam trig_t ENT = trig_entry(g);
    assign rom_w[g] = ENT;
  end

  always_ff @(posedge clk) begin
    trig_r <= rom_w[addr];
  end

  assign trig = trig_r;

endmodule
`default_nettype wire

>>> rtl/pss_scale.sv
// Point scaler: radius times cosine and sine, truncated toward zero, registered.
`default_nettype none
module pss_scale
  import pss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic [RAD_W-1:0] radius,
  input  wire trig_t            trig,
  output pss_point_t            point
);

  logic [PROD_W-1:0] prod_x;
  logic [PROD_W-1:0] prod_y;
  pss_point_t        point_r;

  assign prod_x = PROD_W'(radius) * PROD_W'(trig.mag_c);
  assign prod_y = PROD_W'(radius) * PROD_W'(trig.mag_s);

  // magnitude product shifted right: truncation toward zero once the sign is put back
  always_ff @(posedge clk) begin
    point_r.neg_x <= trig.neg_c;
    point_r.mag_x <= prod_x[PROD_W-1 -: DELTA_W];
    point_r.neg_y <= trig.neg_s;
    point_r.mag_y <= prod_y[PROD_W-1 -: DELTA_W];
  end

  assign point = point_r;

endmodule
`default_nettype wire

>>> rtl/pss_div.sv
// Iterative unit computing floor(a*b/d), one quotient bit per cycle.
`default_nettype none
module pss_div
  import pss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic [DELTA_W-1:0] a,
  input  wire logic [DELTA_W-1:0] b,
  input  wire logic [DELTA_W-1:0] d,
  output logic                    done,
  output logic [DELTA_W-1:0]      quot
);

  localparam int CNT_W = $clog2(DELTA_W + 1);

  typedef enum logic [1:0] {D_IDLE, D_MUL, D_DIV} div_state_t;

  div_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [DELTA_W-1:0]     a_r, a_nxt;
  logic [DELTA_W-1:0]     b_r, b_nxt;
  logic [DELTA_W-1:0]     d_r, d_nxt;
  logic [DELTA_W-1:0]     rem_r, rem_nxt;
  logic [DELTA_W-1:0]     low_r, low_nxt;
  logic                   done_r, done_nxt;
  logic [2*DELTA_W-1:0]   prod;
  logic [DELTA_W:0]       trial;

  assign prod  = (2*DELTA_W)'(a_r) * (2*DELTA_W)'(b_r);
  assign trial = {rem_r, low_r[DELTA_W-1]};

  // b <= d, so the product's high half is below d and DELTA_W steps give the quotient
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    d_nxt     = d_r;
    rem_nxt   = rem_r;
    low_nxt   = low_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      D_IDLE: begin
        if (start) begin
          a_nxt     = a;
          b_nxt     = b;
          d_nxt     = d;
          state_nxt = D_MUL;
        end
      end
      D_MUL: begin
        rem_nxt   = prod[2*DELTA_W-1:DELTA_W];
        low_nxt   = prod[DELTA_W-1:0];
        cnt_nxt   = '0;
        state_nxt = D_DIV;
      end
      D_DIV: begin
        if (trial >= {1'b0, d_r}) begin
          rem_nxt = DELTA_W'(trial - {1'b0, d_r});
          low_nxt = {low_r[DELTA_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial[DELTA_W-1:0];
          low_nxt = {low_r[DELTA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(DELTA_W - 1)) begin
          done_nxt  = 1'b1;
          state_nxt = D_IDLE;
        end
      end
      default: state_nxt = D_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
      cnt_r   <= cnt_nxt;
      a_r     <= a_nxt;
      b_r     <= b_nxt;
      d_r     <= d_nxt;
      rem_r   <= rem_nxt;
      low_r   <= low_nxt;
    end
  end

  assign done = done_r;
  assign quot = low_r;

endmodule
`default_nettype wire

>>> rtl/pie_sector_scanline_span_core.sv
// Pie sector scanline span: top level with sequencer, arc min/max and edge merge.
//
// Usage: the input channel (in_valid/in_ready) carries a sector index, a screen
// row and a fill color. For each transfer the block returns exactly one result
// on the output channel (out_valid/out_ready): span_valid, x_left, span_length
// and the echoed row and color. When no span is drawn, x_left and span_length
// are zero.
// After the input transfer, the 181 arc points of the sector stream through
// the cos/sin table and the radius multipliers at one per cycle, then the
// pipeline drains. Each radial edge goes through the shared divider when the
// row crosses it and is skipped when it does not, and the S_FINAL state hands
// the result to the output register. One item is in work at a time; in_ready
// is high only between items.
// The result sits in an output register; the next item can be taken while it
// waits. If the receiver stalls, the finished item waits in the sequencer until
// the output register is free.
// Configuration (cfg_we/cfg_index/cfg_data) is to be written only while idle
// by the user; the block does not enforce it. Indexes past the register list
// are ignored. Synchronous reset restores the default wheel and screen setup
// and empties both channels.
`default_nettype none
module pie_sector_scanline_span_core
  import pss_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SEC_W-1:0]      in_sector,
  input  wire logic [ROW_W-1:0]      in_row,
  input  wire logic [COLOR_W-1:0]    in_fill_color,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_span_valid,
  output logic [ROW_W-1:0]           out_x_left,
  output logic [LEN_W-1:0]           out_span_length,
  output logic [ROW_W-1:0]           out_span_row,
  output logic [COLOR_W-1:0]         out_span_color
);

  typedef enum logic [2:0] {
    S_IDLE, S_ARC, S_DRAIN, S_EDGE, S_EDGE_WAIT, S_FINAL
  } state_t;

  localparam logic [1:0] HITS_NEED = 2'd2;

  function automatic logic signed [COORD_W-1:0] offs(logic [CX_W-1:0] base, logic neg,
                                                      logic [DELTA_W-1:0] mag);
    logic signed [COORD_W-1:0] b;
    logic signed [COORD_W-1:0] m;
    b = $signed(COORD_W'(base));
    m = $signed(COORD_W'(mag));
    return neg ? (b - m) : (b + m);
  endfunction

  state_t                    state_r, state_nxt;
  logic [CX_W-1:0]           cx_r, cx_nxt;
  logic [CX_W-1:0]           cy_r, cy_nxt;
  logic [RAD_W-1:0]          rad_r, rad_nxt;
  logic [SCR_W-1:0]          sw_r, sw_nxt;
  logic [SCR_W-1:0]          sh_r, sh_nxt;
  logic [ROW_W-1:0]          row_r, row_nxt;
  logic [COLOR_W-1:0]        color_r, color_nxt;
  logic [NM_W-1:0]           nm_r, nm_nxt;
  logic [SAMPLE_W-1:0]       cnt_r, cnt_nxt;
  logic                      v1_r, v1_nxt, first1_r, first1_nxt, last1_r, last1_nxt;
  logic                      v2_r, v2_nxt, first2_r, first2_nxt, last2_r, last2_nxt;
  pss_point_t                e1_r, e1_nxt, e2_r, e2_nxt;
  logic signed [COORD_W-1:0] xl_r, xl_nxt, xr_r, xr_nxt;
  logic [1:0]                hits_r, hits_nxt;
  logic                      edge_sel_r, edge_sel_nxt;
  logic                      ov_r, ov_nxt;
  logic                      osv_r, osv_nxt;
  logic [ROW_W-1:0]          oxl_r, oxl_nxt;
  logic [LEN_W-1:0]          olen_r, olen_nxt;
  logic [ROW_W-1:0]          orow_r, orow_nxt;
  logic [COLOR_W-1:0]        ocol_r, ocol_nxt;

  logic [NM_W-1:0]           base_w [SECTOR_CODES];
  trig_t                     trig;
  pss_point_t                pt;
  pss_point_t                cur;
  logic signed [COORD_W-1:0] row_s, x_arc, y_arc, x_edge;
  logic signed [COORD_W-1:0] dr, dr_abs, my_s;
  logic                      edge_ok;
  logic                      div_start, div_done;
  logic [DELTA_W-1:0]        div_quot;
  logic                      merge_en;
  logic signed [COORD_W-1:0] merge_x;
  logic signed [COORD_W-1:0] y1, y2, cy_s, ymin, ymax, wm1, xl_c, xr_c, len_c;
  logic [SCR_W-1:0]          w_clip;
  logic                      in_range, span_ok;

  for (genvar g = 0; g < SECTOR_CODES; g++) begin : g_base
    localparam int BASE = (g * ARC_SAMPLES) % TRIG_D;
    assign base_w[g] = NM_W'(BASE);
  end

  pss_trig_rom u_rom (
    .clk  (clk),
    .addr (nm_r),
    .trig (trig)
  );

  pss_scale u_scale (
    .clk    (clk),
    .radius (rad_r),
    .trig   (trig),
    .point  (pt)
  );

  pss_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .a     (cur.mag_x),
    .b     (dr_abs[DELTA_W-1:0]),
    .d     (cur.mag_y),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign in_ready = (state_r == S_IDLE);
  assign row_s    = $signed(COORD_W'(row_r));
  assign x_arc    = offs(cx_r, pt.neg_x, pt.mag_x);
  assign y_arc    = offs(cy_r, pt.neg_y, pt.mag_y);

  // edge crossing: row must lie between the center row and the edge end
  assign cur     = edge_sel_r ? e2_r : e1_r;
  assign dr      = row_s - $signed(COORD_W'(cy_r));
  assign dr_abs  = dr[COORD_W-1] ? -dr : dr;
  assign my_s    = $signed(COORD_W'(cur.mag_y));
  assign edge_ok = (cur.mag_y != '0) &&
                   (cur.neg_y ? (!dr[COORD_W-1] ? (dr == '0) : (dr_abs <= my_s))
                              : (!dr[COORD_W-1] && (dr <= my_s)));
  assign x_edge  = offs(cx_r, cur.neg_x, div_quot);

  assign merge_en = (v2_r && (y_arc == row_s)) || ((state_r == S_EDGE_WAIT) && div_done);
  assign merge_x  = (state_r == S_EDGE_WAIT) ? x_edge : x_arc;

  // row range and clipping
  always_comb begin
    y1   = offs(cy_r, e1_r.neg_y, e1_r.mag_y);
    y2   = offs(cy_r, e2_r.neg_y, e2_r.mag_y);
    cy_s = $signed(COORD_W'(cy_r));
    ymin = cy_s;
    ymax = cy_s;
    if (y1 < ymin) ymin = y1;
    if (y2 < ymin) ymin = y2;
    if (y1 > ymax) ymax = y1;
    if (y2 > ymax) ymax = y2;
    in_range = (row_s >= ymin) && (row_s <= ymax) && (SCR_W'(row_r) < sh_r);
    w_clip   = (sw_r > SCR_W'(MAX_COLS)) ? SCR_W'(MAX_COLS) : sw_r;
    wm1      = $signed(COORD_W'(w_clip)) - COORD_W'(1);
    xl_c     = xl_r[COORD_W-1] ? '0 : xl_r;
    xr_c     = (xr_r > wm1) ? wm1 : xr_r;
    span_ok  = in_range && (hits_r == HITS_NEED) && (xr_c >= xl_c);
    len_c    = xr_c - xl_c + COORD_W'(1);
  end

  always_comb begin
    state_nxt    = state_r;
    cx_nxt       = cx_r;
    cy_nxt       = cy_r;
    rad_nxt      = rad_r;
    sw_nxt       = sw_r;
    sh_nxt       = sh_r;
    row_nxt      = row_r;
    color_nxt    = color_r;
    nm_nxt       = nm_r;
    cnt_nxt      = cnt_r;
    v1_nxt       = (state_r == S_ARC);
    first1_nxt   = (cnt_r == '0);
    last1_nxt    = (cnt_r == SAMPLE_W'(ARC_SAMPLES));
    v2_nxt       = v1_r;
    first2_nxt   = first1_r;
    last2_nxt    = last1_r;
    e1_nxt       = e1_r;
    e2_nxt       = e2_r;
    xl_nxt       = xl_r;
    xr_nxt       = xr_r;
    hits_nxt     = hits_r;
    edge_sel_nxt = edge_sel_r;
    ov_nxt       = ov_r;
    osv_nxt      = osv_r;
    oxl_nxt      = oxl_r;
    olen_nxt     = olen_r;
    orow_nxt     = orow_r;
    ocol_nxt     = ocol_r;
    div_start    = 1'b0;

    if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CENTER_X:      cx_nxt  = cfg_data[CX_W-1:0];
        REG_CENTER_Y:      cy_nxt  = cfg_data[CX_W-1:0];
        REG_WHEEL_RADIUS:  rad_nxt = cfg_data[RAD_W-1:0];
        REG_SCREEN_WIDTH:  sw_nxt  = cfg_data[SCR_W-1:0];
        REG_SCREEN_HEIGHT: sh_nxt  = cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end

    if (ov_r && out_ready) ov_nxt = 1'b0;

    if (v2_r && first2_r) e1_nxt = pt;
    if (v2_r && last2_r)  e2_nxt = pt;

    if (merge_en) begin
      if ((hits_r == '0) || (merge_x < xl_r)) xl_nxt = merge_x;
      if ((hits_r == '0) || (merge_x > xr_r)) xr_nxt = merge_x;
      if (hits_r != HITS_NEED) hits_nxt = hits_r + 2'd1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          row_nxt      = in_row;
          color_nxt    = in_fill_color;
          nm_nxt       = base_w[in_sector];
          cnt_nxt      = '0;
          hits_nxt     = '0;
          edge_sel_nxt = 1'b0;
          state_nxt    = S_ARC;
        end
      end
      S_ARC: begin
        nm_nxt  = (nm_r == NM_W'(TRIG_D - 1)) ? '0 : nm_r + NM_W'(1);
        cnt_nxt = cnt_r + SAMPLE_W'(1);
        if (cnt_r == SAMPLE_W'(ARC_SAMPLES)) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) state_nxt = S_EDGE;
      end
      S_EDGE: begin
        if (edge_ok) begin
          div_start = 1'b1;
          state_nxt = S_EDGE_WAIT;
        end else if (edge_sel_r) begin
          state_nxt = S_FINAL;
        end else begin
          edge_sel_nxt = 1'b1;
        end
      end
      S_EDGE_WAIT: begin
        if (div_done) begin
          if (edge_sel_r) begin
            state_nxt = S_FINAL;
          end else begin
            edge_sel_nxt = 1'b1;
            state_nxt    = S_EDGE;
          end
        end
      end
      S_FINAL: begin
        if (!ov_r || out_ready) begin
          ov_nxt    = 1'b1;
          osv_nxt   = span_ok;
          oxl_nxt   = span_ok ? xl_c[ROW_W-1:0] : '0;
          olen_nxt  = span_ok ? len_c[LEN_W-1:0] : '0;
          orow_nxt  = row_r;
          ocol_nxt  = color_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cx_r       <= CX_W'(160);
      cy_r       <= CX_W'(120);
      rad_r      <= RAD_W'(100);
      sw_r       <= SCR_W'(320);
      sh_r       <= SCR_W'(240);
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      hits_r     <= '0;
      edge_sel_r <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cx_r       <= cx_nxt;
      cy_r       <= cy_nxt;
      rad_r      <= rad_nxt;
      sw_r       <= sw_nxt;
      sh_r       <= sh_nxt;
      v1_r       <= v1_nxt;
      v2_r       <= v2_nxt;
      hits_r     <= hits_nxt;
      edge_sel_r <= edge_sel_nxt;
      ov_r       <= ov_nxt;
      row_r      <= row_nxt;
      color_r    <= color_nxt;
      nm_r       <= nm_nxt;
      cnt_r      <= cnt_nxt;
      first1_r   <= first1_nxt;
      last1_r    <= last1_nxt;
      first2_r   <= first2_nxt;
      last2_r    <= last2_nxt;
      e1_r       <= e1_nxt;
      e2_r       <= e2_nxt;
      xl_r       <= xl_nxt;
      xr_r       <= xr_nxt;
      osv_r      <= osv_nxt;
      oxl_r      <= oxl_nxt;
      olen_r     <= olen_nxt;
      orow_r     <= orow_nxt;
      ocol_r     <= ocol_nxt;
    end
  end

  assign out_valid       = ov_r;
  assign out_span_valid  = osv_r;
  assign out_x_left      = oxl_r;
  assign out_span_length = olen_r;
  assign out_span_row    = orow_r;
  assign out_span_color  = ocol_r;

endmodule
`default_nettype wire

>>> sim/testbench.sv
// Testbench for the pie sector span core: directed and random rows against a span predictor.
`timescale 1ns / 1ps
module testbench
  import pss_pkg::*;
();

  typedef longint unsigned u64_t;

  localparam int   NUM_REGS       = 5;
  localparam int   PHASE_ITEMS    = 110;
  localparam int   RANDOM_PHASES  = 7;
  localparam int   FIXED_PHASES   = 6;
  localparam int   LONG_HOLD      = 1500;
  localparam int   HOLD_AFTER     = 30;
  localparam int   SETTLE_CYCLES  = 300;
  localparam int   WATCHDOG_LIMIT = 8000;
  localparam int   CLIP_COLS      = 1024;
  localparam int   ROW_MAX        = (1 << ROW_W) - 1;
  localparam u64_t ANGLE_PI       = 64'd3373259426;
  localparam u64_t UNIT_Q30       = 64'd1 << 30;
  localparam u64_t Q15_TOP        = 64'd32767;

  typedef struct packed {
    logic [SEC_W-1:0]   sector;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] color;
  } row_req_t;

  typedef struct packed {
    logic               span_valid;
    logic [ROW_W-1:0]   x_left;
    logic [LEN_W-1:0]   span_len;
    logic [ROW_W-1:0]   row;
    logic [COLOR_W-1:0] color;
  } span_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [SEC_W-1:0]      in_sector = '0;
  logic [ROW_W-1:0]      in_row = '0;
  logic [COLOR_W-1:0]    in_fill_color = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  out_span_valid;
  logic [ROW_W-1:0]      out_x_left;
  logic [LEN_W-1:0]      out_span_length;
  logic [ROW_W-1:0]      out_span_row;
  logic [COLOR_W-1:0]    out_span_color;

  // predictor copy of the wheel and screen setup (reset values)
  int unsigned wheel_cx = 160;
  int unsigned wheel_cy = 120;
  int unsigned wheel_r  = 100;
  int unsigned wheel_w  = 320;
  int unsigned wheel_h  = 240;

  int cos_q15[TRIG_D];
  int sin_q15[TRIG_D];

  row_req_t pending_items[$];
  span_t    expected_spans[$];
  row_req_t cur_req;

  bit idle_on = 1'b1;
  bit long_hold_done = 1'b0;
  int in_gap = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int fail_count = 0;
  int rows_sent = 0;
  int results_checked = 0;
  int spans_drawn = 0;
  int settings_used = 1;

  int fixed_wheels[FIXED_PHASES][NUM_REGS] = '{
    '{0, 0, 511, 1024, 1024},
    '{1023, 1023, 511, 2047, 2047},
    '{500, 500, 0, 1024, 1024},
    '{160, 120, 100, 0, 240},
    '{160, 120, 100, 320, 0},
    '{0, 0, 1, 1, 1}
  };

  pie_sector_scanline_span_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sector      (in_sector),
    .in_row         (in_row),
    .in_fill_color  (in_fill_color),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_span_valid (out_span_valid),
    .out_x_left     (out_x_left),
    .out_span_length(out_span_length),
    .out_span_row   (out_span_row),
    .out_span_color (out_span_color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic u64_t mul_q30(u64_t a, u64_t b);
    return (a * b) >> 30;
  endfunction

  function automatic u64_t q30_to_q15(u64_t v);
    u64_t q;
    q = (v + 64'd16384) >> 15;
    return (q > Q15_TOP) ? Q15_TOP : q;
  endfunction

  // Q1.15 cosine and sine at turn index nm of TRIG_D
  function automatic void turn_trig(input int unsigned nm, output int co, output int si);
    u64_t        p64, x, t, t2, a, s, c;
    logic [31:0] ph;
    logic        fold;
    int          sq, cq, cb, sb;
    p64  = (u64_t'(nm) << 32) / u64_t'(TRIG_D);
    ph   = p64[31:0];
    fold = ph[29:0] > 30'h2000_0000;
    x    = fold ? (UNIT_Q30 - u64_t'(ph[29:0])) : u64_t'(ph[29:0]);
    t    = (x * ANGLE_PI) >> 31;
    t2   = mul_q30(t, t);

    a = UNIT_Q30 - t2 / 42;
    a = UNIT_Q30 - mul_q30(t2, a) / 20;
    a = UNIT_Q30 - mul_q30(t2, a) / 6;
    s = mul_q30(t, a);

    a = UNIT_Q30 - t2 / 56;
    a = UNIT_Q30 - mul_q30(t2, a) / 30;
    a = UNIT_Q30 - mul_q30(t2, a) / 12;
    c = UNIT_Q30 - mul_q30(t2, a) / 2;

    sq = int'(q30_to_q15(s));
    cq = int'(q30_to_q15(c));
    cb = fold ? sq : cq;
    sb = fold ? cq : sq;
    case (ph[31:30])
      2'd0: begin co = cb;  si = sb;  end
      2'd1: begin co = -sb; si = cb;  end
      2'd2: begin co = -cb; si = -sb; end
      default: begin co = sb; si = -cb; end
    endcase
  endfunction

  // radius times Q1.15, truncated toward zero
  function automatic int scale_radius(int q);
    int unsigned mag, m;
    mag = (q < 0) ? -q : q;
    m   = (wheel_r * mag) >> 15;
    return (q < 0) ? -int'(m) : int'(m);
  endfunction

  function automatic void arc_point(input int unsigned n, output int px, output int py);
    int unsigned nm;
    nm = n % TRIG_D;
    px = int'(wheel_cx) + scale_radius(cos_q15[nm]);
    py = int'(wheel_cy) + scale_radius(sin_q15[nm]);
  endfunction

  function automatic bit edge_cross(input int xe, input int ye, input int row, output int xo);
    int     cx, cy;
    longint num;
    cx = int'(wheel_cx);
    cy = int'(wheel_cy);
    xo = 0;
    if (ye == cy) return 1'b0;
    if (!((row >= cy && row <= ye) || (row >= ye && row <= cy))) return 1'b0;
    num = longint'(xe - cx) * longint'(row - cy);
    xo  = cx + int'(num / longint'(ye - cy));
    return 1'b1;
  endfunction

  function automatic void add_hit(input int x, inout int xl, inout int xr, inout int hits);
    if (hits == 0 || x < xl) xl = x;
    if (hits == 0 || x > xr) xr = x;
    hits++;
  endfunction

  function automatic span_t predict_span(row_req_t rq);
    span_t       sp;
    int unsigned base;
    int          cy, w, row, x1, y1, x2, y2, ymin, ymax, xe, xa, ya, xl, xr, hits, i;
    base = 32'(rq.sector) * ARC_SAMPLES;
    cy   = int'(wheel_cy);
    w    = (wheel_w > CLIP_COLS) ? CLIP_COLS : int'(wheel_w);
    row  = int'(rq.row);
    xl   = 0;
    xr   = 0;
    hits = 0;
    sp       = '0;
    sp.row   = rq.row;
    sp.color = rq.color;

    arc_point(base, x1, y1);
    arc_point(base + ARC_SAMPLES, x2, y2);
    ymin = cy;
    ymax = cy;
    if (y1 < ymin) ymin = y1;
    if (y2 < ymin) ymin = y2;
    if (y1 > ymax) ymax = y1;
    if (y2 > ymax) ymax = y2;
    if (ymin < 0) ymin = 0;
    if (ymax >= int'(wheel_h)) ymax = int'(wheel_h) - 1;
    if (row < ymin || row > ymax) return sp;

    if (edge_cross(x1, y1, row, xe)) add_hit(xe, xl, xr, hits);
    if (edge_cross(x2, y2, row, xe)) add_hit(xe, xl, xr, hits);
    for (i = 0; i <= ARC_SAMPLES; i++) begin
      arc_point(base + i, xa, ya);
      if (ya == row) add_hit(xa, xl, xr, hits);
    end
    if (hits < 2) return sp;
    if (xl < 0) xl = 0;
    if (xr >= w) xr = w - 1;
    if (xr < xl) return sp;
    xr            = xr - xl + 1;
    sp.span_valid = 1'b1;
    sp.x_left     = xl[ROW_W-1:0];
    sp.span_len   = xr[LEN_W-1:0];
    return sp;
  endfunction

  task automatic report_failure(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want)
      report_failure($sformatf("result %0d: %s = 0x%0h, expected 0x%0h",
                               results_checked, name, got, want));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_CENTER_X:      wheel_cx = 32'(val[CX_W-1:0]);
      REG_CENTER_Y:      wheel_cy = 32'(val[CX_W-1:0]);
      REG_WHEEL_RADIUS:  wheel_r  = 32'(val[RAD_W-1:0]);
      REG_SCREEN_WIDTH:  wheel_w  = 32'(val[SCR_W-1:0]);
      REG_SCREEN_HEIGHT: wheel_h  = 32'(val[SCR_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic set_wheel(int cx, int cy, int r, int w, int h);
    write_reg(REG_CENTER_X, cx[CFG_DATA_W-1:0]);
    write_reg(REG_CENTER_Y, cy[CFG_DATA_W-1:0]);
    write_reg(REG_WHEEL_RADIUS, r[CFG_DATA_W-1:0]);
    write_reg(REG_SCREEN_WIDTH, w[CFG_DATA_W-1:0]);
    write_reg(REG_SCREEN_HEIGHT, h[CFG_DATA_W-1:0]);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic push_row(int s, int r, int color);
    row_req_t rq;
    rq.sector = s[SEC_W-1:0];
    rq.row    = r[ROW_W-1:0];
    rq.color  = color[COLOR_W-1:0];
    pending_items.push_back(rq);
  endtask

  // rows mostly inside the wheel's band, some hugging the center row, some anywhere
  task automatic queue_rows(int count);
    int k, pick, margin, lo, hi;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        hi = $urandom_range(0, ROW_MAX);
      end else begin
        margin = (pick < 30) ? 2 : int'(wheel_r) + 2;
        lo = int'(wheel_cy) - margin;
        hi = int'(wheel_cy) + margin;
        if (lo < 0) lo = 0;
        if (hi > ROW_MAX) hi = ROW_MAX;
        hi = $urandom_range(lo, hi);
      end
      push_row($urandom_range(0, SECTOR_CODES - 1), hi, $urandom);
    end
  endtask

  task automatic queue_directed();
    int s, cy, r;
    cy = int'(wheel_cy);
    r  = int'(wheel_r);
    // center row: horizontal radial edges on the axis sectors
    for (s = 0; s < SECTOR_CODES; s++) push_row(s, cy, 16'h0000);
    for (s = 0; s < SECTOR_CODES; s++)
      push_row(s, (s < SECTOR_CODES / 2) ? cy + r / 2 : cy - r / 2, 16'hFFFF);
    push_row(1, cy + r, 16'hFFFF);
    push_row(5, cy - r, 16'h0000);
    push_row(2, cy + r + 1, 16'h5A5A);
    push_row(0, 0, 16'h0000);
    push_row(SECTOR_CODES - 1, ROW_MAX, 16'hFFFF);
    push_row(3, 0, 16'hA5A5);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_spans.size() != 0);
  endtask

  always @(posedge clk) begin : row_driver
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_spans.push_back(predict_span(cur_req));
        rows_sent++;
      end
      if (!in_valid || in_ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_req = pending_items.pop_front();
          in_valid      <= 1'b1;
          in_sector     <= cur_req.sector;
          in_row        <= cur_req.row;
          in_fill_color <= cur_req.color;
          if (idle_on && $urandom_range(0, 3) == 0) in_gap = $urandom_range(1, 3);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : span_monitor
    span_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_checked++;
        if (expected_spans.size() == 0) begin
          report_failure($sformatf("result %0d arrived with no transfer pending",
                                   results_checked));
        end else begin
          want = expected_spans.pop_front();
          if (want.span_valid) spans_drawn++;
          check_field("span_valid", 32'(out_span_valid), 32'(want.span_valid));
          check_field("x_left", 32'(out_x_left), 32'(want.x_left));
          check_field("span_length", 32'(out_span_length), 32'(want.span_len));
          check_field("span_row", 32'(out_span_row), 32'(want.row));
          check_field("span_color", 32'(out_span_color), 32'(want.color));
        end
      end
      // one long back-pressure stretch so the block fills and stalls its input
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_checked >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        hold_left = $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles", quiet_cycles);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int k, ph;
    for (k = 0; k < TRIG_D; k++) turn_trig(k, cos_q15[k], sin_q15[k]);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    queue_directed();
    queue_rows(PHASE_ITEMS);
    wait_drained();

    for (ph = 0; ph < FIXED_PHASES; ph++) begin
      set_wheel(fixed_wheels[ph][0], fixed_wheels[ph][1], fixed_wheels[ph][2],
                fixed_wheels[ph][3], fixed_wheels[ph][4]);
      queue_rows(PHASE_ITEMS);
      wait_drained();
    end

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      if (ph == RANDOM_PHASES - 1) idle_on = 1'b0;
      // indexes past the register list must be ignored
      for (k = NUM_REGS; k < (1 << CFG_IDX_W); k++)
        write_reg(k[CFG_IDX_W-1:0], CFG_DATA_W'($urandom));
      set_wheel($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom_range(0, 2047),
                $urandom_range(0, 2047), $urandom_range(0, 2047));
      queue_rows(PHASE_ITEMS);
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_spans.size() != 0)
      report_failure($sformatf("%0d spans never came out", expected_spans.size()));

    $display("Covered %0d row requests over %0d wheel/screen setups, back-pressure included.",
             rows_sent, settings_used);
    $display("Checked %0d results, %0d of them drawn spans; %0d mismatches.",
             results_checked, spans_drawn, fail_count);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
